[rtl/core/sosc_pkg.sv]
package sosc_pkg;

  // Field widths
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned PCT_W   = 23;
  localparam int unsigned KPER_W  = 7;
  localparam int unsigned DPER_W  = 4;
  // %K sum over up to 15 entries
  localparam int unsigned SUM_W   = PCT_W + DPER_W;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Fixed-point constants (16 fraction bits)
  localparam logic [6:0]       HUNDRED  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HALF = 23'd3276800;
  localparam logic [PCT_W-1:0] PCT_MAX  = 23'd6553600;

  // Register reset values
  localparam logic [KPER_W-1:0] K_PERIOD_RST = 7'd14;
  localparam logic [DPER_W-1:0] D_PERIOD_RST = 4'd3;

  // Register map, indexed by paddr[2]
  typedef enum logic {
    REG_K_PERIOD = 1'b0,
    REG_D_PERIOD = 1'b1
  } sosc_reg_e;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               restart;
  } sosc_in_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct_k;
    logic [PCT_W-1:0] pct_d;
    logic             k_valid;
    logic             d_valid;
  } sosc_out_t;

endpackage

[rtl/core/stochastic_oscillator.sv]
// Stochastic oscillator (%K/%D). One request carries one price sample and
// returns one result: %K = (price - low) / (high - low) * 100 and %D, the
// mean of the last D %K values (D the %D length register, clamped to
// 1..MAX_D_PERIOD), both as unsigned values with 16 fraction bits, truncated.
// A flat window gives %K = 50; both outputs are 0 with their valid bits low
// until enough samples exist since the last restart. The time from accept
// to result is set by the window scan, which reads one price from the
// window RAM per cycle, and by one shared 23-step restoring divider that
// produces %K and then %D; a flat window skips the %K divide, a request
// while %D is not yet valid skips the %D sum and divide, and a partial
// window skips the scan and both divides. in_stall_o is high while a
// request is in progress. The user must write registers over the APB port
// only while the block is idle; the block itself does not enforce this.
module stochastic_oscillator
  import sosc_pkg::*;
#(
  parameter int unsigned MAX_K_PERIOD = 64,
  parameter int unsigned MAX_D_PERIOD = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sosc_in_t            in_data_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sosc_out_t           out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned AW   = $clog2(MAX_K_PERIOD);
  localparam int unsigned HW   = (MAX_D_PERIOD > 1) ? $clog2(MAX_D_PERIOD) : 1;
  localparam int unsigned CMPW = HW + DPER_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_DIVK,
    ST_HIST,
    ST_SUM,
    ST_DIVD,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [KPER_W-1:0] k_period_q;
  logic [DPER_W-1:0] d_len_q;

  // series state
  logic [KPER_W-1:0] sample_count_q;
  logic [AW-1:0]     write_slot_q;

  // per-request working registers
  logic [PRICE_W-1:0] price_q;
  logic [PRICE_W-1:0] lo_q, hi_q;
  logic [DPER_W-1:0]  d_eff_q;
  logic               kv_q, dv_q;
  logic [AW-1:0]      rd_idx_q;
  logic [KPER_W-1:0]  scan_cnt_q;
  logic               rd_vld_q;
  logic [PCT_W-1:0]   pk_q, pd_q;
  logic [SUM_W-1:0]   sum_q;
  logic [HW-1:0]      sum_idx_q;

  // shared divider
  logic [PRICE_W-1:0] div_rem_q;
  logic [PRICE_W-1:0] div_den_q;
  logic [PCT_W-1:0]   div_low_q;
  logic [4:0]         div_cnt_q;

  // output register
  logic      out_valid_q;
  sosc_out_t out_data_q;

  // storage
  logic [PRICE_W-1:0] price_mem [MAX_K_PERIOD];
  logic [PRICE_W-1:0] rd_data_q;
  logic [PCT_W-1:0]   hist_q [MAX_D_PERIOD];

  // combinational helpers
  logic               in_acc;
  logic               cfg_wr;
  logic               out_load;
  logic [KPER_W-1:0]  k_eff;
  logic [DPER_W-1:0]  d_eff;
  logic [AW-1:0]      slot_new;
  logic [KPER_W-1:0]  count_base;
  logic [KPER_W-1:0]  count_new;
  logic               kv_new, dv_new;
  logic [PRICE_W-1:0] price_diff;
  logic [PRICE_W-1:0] price_rng;
  logic [38:0]        prod;
  logic [PRICE_W:0]   div_sh;
  logic [PRICE_W:0]   div_den_ext;
  logic               div_qbit;
  logic [PRICE_W-1:0] div_rem_nxt;
  logic [PCT_W-1:0]   div_low_nxt;
  logic [SUM_W-1:0]   sum_nxt;
  logic               sum_last;
  logic [PRICE_W-1:0] lo_nxt, hi_nxt;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // register readback
  always_comb begin
    unique case (sosc_reg_e'(paddr[2]))
      REG_K_PERIOD: prdata = {{(APB_DW-KPER_W){1'b0}}, k_period_q};
      REG_D_PERIOD: prdata = {{(APB_DW-DPER_W){1'b0}}, d_len_q};
      default:      prdata = '0;
    endcase
  end

  // effective periods, sample bookkeeping
  always_comb begin
    if (k_period_q == '0) begin
      k_eff = 7'd1;
    end else if (32'(k_period_q) > MAX_K_PERIOD) begin
      k_eff = KPER_W'(MAX_K_PERIOD);
    end else begin
      k_eff = k_period_q;
    end
    if (d_len_q == '0) begin
      d_eff = 4'd1;
    end else if (32'(d_len_q) > MAX_D_PERIOD) begin
      d_eff = DPER_W'(MAX_D_PERIOD);
    end else begin
      d_eff = d_len_q;
    end
    slot_new   = in_data_i.restart ? '0 : write_slot_q;
    count_base = in_data_i.restart ? '0 : sample_count_q;
    count_new  = (count_base == '1) ? count_base : count_base + 7'd1;
    kv_new     = (count_new >= k_eff);
    dv_new     = ({1'b0, count_new} >= ({1'b0, k_eff} + 8'(d_eff) - 8'd1));
  end

  // window min/max compare
  always_comb begin
    lo_nxt = lo_q;
    hi_nxt = hi_q;
    if (rd_vld_q) begin
      if (rd_data_q < lo_q) lo_nxt = rd_data_q;
      if (rd_data_q > hi_q) hi_nxt = rd_data_q;
    end
  end

  // scaled difference: (price - low) * 100, then shifted by 16 for the divide
  assign price_diff = price_q - lo_q;
  assign price_rng  = hi_q - lo_q;
  assign prod       = 39'(price_diff) * 39'(HUNDRED);

  // one restoring-divide step; quotient bits shift into div_low_q
  always_comb begin
    div_sh      = {div_rem_q, div_low_q[PCT_W-1]};
    div_den_ext = {1'b0, div_den_q};
    div_qbit    = (div_sh >= div_den_ext);
    div_rem_nxt = div_qbit ? PRICE_W'(div_sh - div_den_ext) : div_sh[PRICE_W-1:0];
    div_low_nxt = {div_low_q[PCT_W-2:0], div_qbit};
  end

  // %K history accumulate
  assign sum_nxt  = sum_q + SUM_W'(hist_q[sum_idx_q]);
  assign sum_last = ({{DPER_W{1'b0}}, sum_idx_q} == CMPW'(d_eff_q - 4'd1));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_period_q <= K_PERIOD_RST;
      d_len_q    <= D_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (sosc_reg_e'(paddr[2]))
        REG_K_PERIOD: k_period_q <= pwdata[KPER_W-1:0];
        REG_D_PERIOD: d_len_q    <= pwdata[DPER_W-1:0];
        default: ;
      endcase
    end
  end

  // price window RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      price_mem[slot_new] <= in_data_i.price;
    end
    if (state_q == ST_SCAN) begin
      rd_data_q <= price_mem[rd_idx_q];
    end
  end

  // %K history shift line
  always_ff @(posedge clk_i) begin
    if (state_q == ST_HIST) begin
      hist_q[0] <= pk_q;
      for (int j = 1; j < MAX_D_PERIOD; j++) begin
        hist_q[j] <= hist_q[j-1];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sample_count_q <= '0;
      write_slot_q   <= '0;
      rd_vld_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      price_q        <= '0;
      lo_q           <= '0;
      hi_q           <= '0;
      d_eff_q        <= '0;
      kv_q           <= 1'b0;
      dv_q           <= 1'b0;
      rd_idx_q       <= '0;
      scan_cnt_q     <= '0;
      pk_q           <= '0;
      pd_q           <= '0;
      sum_q          <= '0;
      sum_idx_q      <= '0;
      div_rem_q      <= '0;
      div_den_q      <= '0;
      div_low_q      <= '0;
      div_cnt_q      <= '0;
      out_data_q     <= '0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      // output valid: set by the output step, cleared once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            write_slot_q   <= (slot_new == AW'(MAX_K_PERIOD - 1)) ? '0 : slot_new + 1'b1;
            sample_count_q <= count_new;
            price_q        <= in_data_i.price;
            lo_q           <= in_data_i.price;
            hi_q           <= in_data_i.price;
            d_eff_q        <= d_eff;
            kv_q           <= kv_new;
            dv_q           <= dv_new;
            rd_idx_q       <= slot_new;
            scan_cnt_q     <= k_eff;
            pk_q           <= '0;
            pd_q           <= '0;
            state_q        <= kv_new ? ST_SCAN : ST_HIST;
          end
        end

        // issue one window read per cycle, walking back from the newest slot
        ST_SCAN: begin
          lo_q       <= lo_nxt;
          hi_q       <= hi_nxt;
          rd_idx_q   <= (rd_idx_q == '0) ? AW'(MAX_K_PERIOD - 1) : rd_idx_q - 1'b1;
          scan_cnt_q <= scan_cnt_q - 7'd1;
          if (scan_cnt_q == 7'd1) state_q <= ST_DRAIN;
        end

        // last read returns
        ST_DRAIN: begin
          lo_q    <= lo_nxt;
          hi_q    <= hi_nxt;
          state_q <= ST_MUL;
        end

        // scale, then load divider with the high part of the dividend; a flat window gives %K = 50
        ST_MUL: begin
          if (price_rng == '0) begin
            pk_q    <= PCT_HALF;
            state_q <= ST_HIST;
          end else begin
            div_rem_q <= prod[38:7];
            div_low_q <= {prod[6:0], 16'b0};
            div_den_q <= price_rng;
            div_cnt_q <= 5'(PCT_W - 1);
            state_q   <= ST_DIVK;
          end
        end

        ST_DIVK: begin
          div_rem_q <= div_rem_nxt;
          div_low_q <= div_low_nxt;
          div_cnt_q <= div_cnt_q - 5'd1;
          if (div_cnt_q == '0) begin
            pk_q    <= div_low_nxt;
            state_q <= ST_HIST;
          end
        end

        ST_HIST: begin
          sum_q     <= '0;
          sum_idx_q <= '0;
          state_q   <= dv_q ? ST_SUM : ST_OUT;
        end

        // add one history entry per cycle
        ST_SUM: begin
          sum_q     <= sum_nxt;
          sum_idx_q <= sum_idx_q + 1'b1;
          if (sum_last) begin
            div_rem_q <= PRICE_W'(sum_nxt[SUM_W-1:PCT_W]);
            div_low_q <= sum_nxt[PCT_W-1:0];
            div_den_q <= PRICE_W'(d_eff_q);
            div_cnt_q <= 5'(PCT_W - 1);
            state_q   <= ST_DIVD;
          end
        end

        ST_DIVD: begin
          div_rem_q <= div_rem_nxt;
          div_low_q <= div_low_nxt;
          div_cnt_q <= div_cnt_q - 5'd1;
          if (div_cnt_q == '0) begin
            pd_q    <= div_low_nxt;
            state_q <= ST_OUT;
          end
        end

        // hand over to the output register once it is free
        ST_OUT: begin
          if (out_load) begin
            out_data_q.pct_k   <= pk_q;
            out_data_q.pct_d   <= pd_q;
            out_data_q.k_valid <= kv_q;
            out_data_q.d_valid <= dv_q;
            state_q            <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a request keeps the input side busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a request");

  // %D is only valid together with %K
  a_d_needs_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.d_valid |-> out_data_o.k_valid)
    else $error("d_valid without k_valid");

  // outputs are zero when not valid and %K stays within 0..100
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pct_k <= PCT_MAX) &&
                    (out_data_o.k_valid || out_data_o.pct_k == '0) &&
                    (out_data_o.d_valid || out_data_o.pct_d == '0))
    else $error("result out of range or nonzero while invalid");

  // a new result only appears after the sequencer passed its output step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result presented outside the output step");

endmodule
